FILE: sv/dnwl_pkg.sv
// ----------------------------------------------------------------------------
// dnwl_pkg
// Shared constants, codes and controller/datapath structs for the dotted
// domain name to wire label converter.
// ----------------------------------------------------------------------------
package dnwl_pkg;

	localparam int MAX_LABEL   = 63;
	localparam int MAX_NAME    = 255;
	localparam int STORE_DEPTH = 63;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
	localparam int COUNT_W     = 8;

	localparam logic [7:0]         DOT_CHAR  = 8'h2E;
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(255);
	localparam logic [COUNT_W-1:0] NAME_LIM  = COUNT_W'(MAX_NAME);
	localparam logic [FILL_W-1:0]  LABEL_LIM = FILL_W'(MAX_LABEL);

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_EMPTY      = 2'd1,
		ERR_NAME_LONG  = 2'd2,
		ERR_LABEL_LONG = 2'd3
	} err_t;

	typedef enum logic {
		CMD_CHAR = 1'b0,
		CMD_END  = 1'b1
	} in_cmd_t;

	typedef struct packed {
		logic accept;
		logic push_len;
		logic push_data;
		logic push_end;
	} dnwl_cmd_t;

	typedef struct packed {
		logic flush;
		logic is_end;
		logic out_free;
		logic data_last;
	} dnwl_stat_t;

endpackage

FILE: sv/dnwl_in_if.sv
// ----------------------------------------------------------------------------
// dnwl_in_if
// Name character channel: one word is a character or an end of name mark.
// ----------------------------------------------------------------------------
interface dnwl_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] text_char;

	modport source (output valid, output cmd, output text_char, input ready);
	modport sink (input valid, input cmd, input text_char, output ready);
endinterface

FILE: sv/dnwl_out_if.sv
// ----------------------------------------------------------------------------
// dnwl_out_if
// Wire format channel: one word is one wire byte with end and error marks.
// ----------------------------------------------------------------------------
interface dnwl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;
	logic       last_of_name;
	logic [1:0] error_code;

	modport source (output valid, output wire_byte, output last_of_name,
		output error_code, input ready);
	modport sink (input valid, input wire_byte, input last_of_name,
		input error_code, output ready);
endinterface

FILE: sv/dnwl_ram.sv
// ----------------------------------------------------------------------------
// dnwl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dnwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/dnwl_ctrl.sv
// ----------------------------------------------------------------------------
// dnwl_ctrl
// Controller: takes words, sequences label flushes and the closing zero byte.
// ----------------------------------------------------------------------------
module dnwl_ctrl
	import dnwl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dnwl_stat_t stat,
	output dnwl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_DATA,
		ST_END
	} state_t;

	state_t state_q;
	logic   end_pend_q;

	always_comb begin
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.accept    = in_valid;
			ST_LEN:  cmd.push_len  = stat.out_free;
			ST_DATA: cmd.push_data = stat.out_free;
			ST_END:  cmd.push_end  = stat.out_free;
			default: cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (stat.flush) begin
							state_q    <= ST_LEN;
							end_pend_q <= stat.is_end;
						end else if (stat.is_end) begin
							state_q <= ST_END;
						end
					end
				end
				ST_LEN: begin
					if (stat.out_free) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (stat.out_free && stat.data_last) begin
						state_q <= end_pend_q ? ST_END : ST_IDLE;
					end
				end
				ST_END: begin
					if (stat.out_free) begin
						state_q    <= ST_IDLE;
						end_pend_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/dnwl_dp.sv
// ----------------------------------------------------------------------------
// dnwl_dp
// Datapath: name counters, error latch, label RAM and output word register.
// ----------------------------------------------------------------------------
module dnwl_dp
	import dnwl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_cmd,
	input  logic [7:0] text_char,
	input  dnwl_cmd_t  cmd,
	output dnwl_stat_t stat,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] wire_byte,
	output logic       last_of_name,
	output logic [1:0] error_code
);

	logic [FILL_W-1:0]  fill_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               closed_q;
	logic [COUNT_W-1:0] chars_q;
	logic [COUNT_W-1:0] ltl_q;
	err_t               err_q;
	err_t               end_err_q;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	err_t               out_err_q;

	logic               is_end;
	logic               is_dot;
	logic [COUNT_W-1:0] chars_inc;
	err_t               err_chr;
	err_t               end_err;
	logic [FILL_W-1:0]  fill_inc;
	logic [FILL_W-1:0]  fill_dec;
	logic               store_en;
	logic               label_full;
	logic               flush_chr;
	logic               flush_end;
	logic               data_last;
	logic               push_any;
	logic               out_free;
	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;

	assign is_end    = (in_cmd == CMD_END);
	assign is_dot    = (text_char == DOT_CHAR);
	assign chars_inc = (chars_q == COUNT_MAX) ? chars_q : chars_q + COUNT_W'(1);
	assign fill_inc  = fill_q + FILL_W'(1);
	assign fill_dec  = fill_q - FILL_W'(1);

	always_comb begin
		err_chr = err_q;
		if (chars_inc >= NAME_LIM) begin
			err_chr = ERR_NAME_LONG;
		end
		if (closed_q && err_chr == ERR_NONE) begin
			err_chr = ERR_LABEL_LONG;
		end
	end

	always_comb begin
		if (ltl_q == '0) begin
			end_err = (chars_q == COUNT_W'(1)) ? ERR_NONE : ERR_EMPTY;
		end else begin
			end_err = err_q;
		end
	end

	assign store_en   = !is_end && !is_dot && (err_chr == ERR_NONE);
	assign label_full = (fill_inc >= LABEL_LIM);
	assign flush_chr  = is_dot ? (err_q == ERR_NONE && fill_q != '0) : (store_en && label_full);
	assign flush_end  = (ltl_q != '0) && (err_q == ERR_NONE) && (fill_q != '0);
	assign data_last  = (FILL_W'(idx_q) == fill_dec);
	assign out_free   = !out_valid_q || out_ready;
	assign push_any   = cmd.push_len || cmd.push_data || cmd.push_end;

	assign stat.flush     = is_end ? flush_end : flush_chr;
	assign stat.is_end    = is_end;
	assign stat.out_free  = out_free;
	assign stat.data_last = data_last;

	// read one ahead while streaming so each cycle can move a byte
	assign raddr = (cmd.push_data && !data_last) ? idx_q + ADDR_W'(1) : idx_q;

	dnwl_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_label_ram (
		.clk   (clk),
		.we    (cmd.accept && store_en),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (text_char),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			idx_q     <= '0;
			closed_q  <= 1'b0;
			chars_q   <= '0;
			ltl_q     <= '0;
			err_q     <= ERR_NONE;
			end_err_q <= ERR_NONE;
		end else begin
			if (cmd.accept) begin
				if (is_end) begin
					chars_q   <= '0;
					ltl_q     <= '0;
					err_q     <= ERR_NONE;
					closed_q  <= 1'b0;
					end_err_q <= end_err;
					if (!flush_end) begin
						fill_q <= '0;
					end
				end else begin
					chars_q <= chars_inc;
					if (is_dot) begin
						closed_q <= 1'b0;
					end else begin
						ltl_q <= chars_inc;
						err_q <= err_chr;
						if (store_en) begin
							fill_q <= fill_inc;
							if (label_full) begin
								closed_q <= 1'b1;
							end
						end
					end
				end
			end
			if (cmd.push_data) begin
				if (data_last) begin
					idx_q  <= '0;
					fill_q <= '0;
				end else begin
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_len) begin
			out_byte_q <= 8'(fill_q);
			out_last_q <= 1'b0;
			out_err_q  <= ERR_NONE;
		end else if (cmd.push_data) begin
			out_byte_q <= rdata;
			out_last_q <= 1'b0;
			out_err_q  <= ERR_NONE;
		end else if (cmd.push_end) begin
			out_byte_q <= 8'd0;
			out_last_q <= 1'b1;
			out_err_q  <= end_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign wire_byte    = out_byte_q;
	assign last_of_name = out_last_q;
	assign error_code   = out_err_q;

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_any |-> out_free)
		else $error("word pushed into a full output register");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.push_len, cmd.push_data, cmd.push_end}))
		else $error("more than one datapath action in a cycle");

	a_data_needs_label: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_len || cmd.push_data) |-> fill_q != '0)
		else $error("label flush with an empty label");

	a_error_blocks_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && err_q != ERR_NONE && !is_end) |=> $stable(fill_q))
		else $error("label stored after an error was latched");

endmodule

FILE: sv/domain_name_to_wire_labels.sv
// ----------------------------------------------------------------------------
// domain_name_to_wire_labels
// Streams a dotted domain name, one character a word, into wire format
// labels: length byte, label bytes, closing zero byte with an error code.
//
//   channel  dir  payload                                   handshake
//   name_ch  in   cmd, text_char                            valid / ready
//   wire_ch  out  wire_byte, last_of_name, error_code       valid / ready
//
// a character that closes no label keeps ST_IDLE; a label flush sends the
// length byte, then one label byte a cycle from the label RAM read port
// unless wire_ch stalls; an end of name adds the zero byte after any flush
// asynchronous reset clears all control state; the label RAM is not cleared
// output words sit in a register; a flush waits there while wire_ch stalls
// ----------------------------------------------------------------------------
module domain_name_to_wire_labels
	import dnwl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	dnwl_in_if.sink           name_ch,
	dnwl_out_if.source        wire_ch
);

	dnwl_cmd_t  cmd;
	dnwl_stat_t stat;

	dnwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (name_ch.valid),
		.in_ready (name_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dnwl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_cmd       (name_ch.cmd),
		.text_char    (name_ch.text_char),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (wire_ch.valid),
		.out_ready    (wire_ch.ready),
		.wire_byte    (wire_ch.wire_byte),
		.last_of_name (wire_ch.last_of_name),
		.error_code   (wire_ch.error_code)
	);

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for domain_name_to_wire_labels. A table of directed
// names (root, empty, dot runs, byte extremes, full labels, overlong labels
// and overlong names) is followed by random names, mostly well formed. Every
// accepted character runs through a behavioral model of the converter, and
// every wire word is checked in order against the words it predicted.
// ----------------------------------------------------------------------------
module tb;
	import dnwl_pkg::*;

	localparam int RANDOM_ITEMS = 48;
	localparam int IDLE_PCT     = 29;
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       last_of_name;
		err_t       error_code;
	} wire_word_t;

	typedef struct {
		in_cmd_t    cmd;
		logic [7:0] ch;
		int         reps;
		logic       typed;
		wire_word_t word;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic steady;

	dnwl_in_if  name_if ();
	dnwl_out_if wire_if ();

	domain_name_to_wire_labels dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.name_ch (name_if),
		.wire_ch (wire_if)
	);

	// label model state
	logic [7:0] label_buf [STORE_DEPTH];
	int         held_len;
	logic       full_closed;
	int         seen_count;
	int         nondot_count;
	err_t       name_err;

	wire_word_t wire_expect_q [$];

	int mismatches;
	int items_sent;
	int names_sent;
	int words_checked;
	int end_codes [4];

	stim_row_t directed_rows [18] = '{
		'{CMD_END,  8'h00, 1,   1'b1, '{8'h00, 1'b1, ERR_EMPTY}},
		'{CMD_CHAR, DOT_CHAR, 1, 1'b0, '0},
		'{CMD_END,  8'hFF, 1,   1'b1, '{8'h00, 1'b1, ERR_NONE}},
		'{CMD_CHAR, DOT_CHAR, 3, 1'b0, '0},
		'{CMD_END,  8'h00, 1,   1'b1, '{8'h00, 1'b1, ERR_EMPTY}},
		'{CMD_CHAR, 8'h00, 1,   1'b0, '0},
		'{CMD_CHAR, 8'hFF, 1,   1'b0, '0},
		'{CMD_CHAR, DOT_CHAR, 2, 1'b0, '0},
		'{CMD_CHAR, 8'h2D, 1,   1'b0, '0},
		'{CMD_CHAR, DOT_CHAR, 1, 1'b0, '0},
		'{CMD_END,  8'h55, 1,   1'b0, '0},
		'{CMD_CHAR, 8'h55, 64,  1'b0, '0},
		'{CMD_CHAR, DOT_CHAR, 1, 1'b0, '0},
		'{CMD_CHAR, 8'h62, 1,   1'b0, '0},
		'{CMD_END,  8'h00, 1,   1'b1, '{8'h00, 1'b1, ERR_LABEL_LONG}},
		'{CMD_CHAR, 8'h33, 63,  1'b0, '0},
		'{CMD_CHAR, 8'hCC, 192, 1'b0, '0},
		'{CMD_END,  8'h00, 1,   1'b1, '{8'h00, 1'b1, ERR_NAME_LONG}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 20)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic flush_label();
		wire_expect_q.push_back('{8'(held_len), 1'b0, ERR_NONE});
		for (int i = 0; i < held_len; i++)
			wire_expect_q.push_back('{label_buf[i], 1'b0, ERR_NONE});
		held_len = 0;
	endtask

	task automatic predict_words(in_cmd_t cmd, logic [7:0] ch);
		if (cmd == CMD_END) begin
			if (nondot_count == 0) begin
				wire_expect_q.push_back('{8'h00, 1'b1,
					(seen_count == 1) ? ERR_NONE : ERR_EMPTY});
			end else if (name_err != ERR_NONE) begin
				wire_expect_q.push_back('{8'h00, 1'b1, name_err});
			end else begin
				if (held_len > 0)
					flush_label();
				wire_expect_q.push_back('{8'h00, 1'b1, ERR_NONE});
			end
			held_len = 0;
			full_closed = 1'b0;
			seen_count = 0;
			nondot_count = 0;
			name_err = ERR_NONE;
		end else begin
			if (seen_count < 255)
				seen_count++;
			if (ch == DOT_CHAR) begin
				if (name_err == ERR_NONE && held_len > 0)
					flush_label();
				full_closed = 1'b0;
			end else begin
				nondot_count = seen_count;
				if (seen_count >= MAX_NAME)
					name_err = ERR_NAME_LONG;
				if (full_closed && name_err == ERR_NONE)
					name_err = ERR_LABEL_LONG;
				if (name_err == ERR_NONE) begin
					label_buf[held_len] = ch;
					held_len++;
					if (held_len >= MAX_LABEL) begin
						flush_label();
						full_closed = 1'b1;
					end
				end
			end
		end
	endtask

	task automatic send_word(in_cmd_t cmd, logic [7:0] ch, logic typed, wire_word_t word);
		int queued;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			name_if.valid <= 1'b0;
			@(posedge clk);
		end
		name_if.valid     <= 1'b1;
		name_if.cmd       <= cmd;
		name_if.text_char <= ch;
		do
			@(posedge clk);
		while (!name_if.ready);
		items_sent++;
		queued = wire_expect_q.size();
		predict_words(cmd, ch);
		if (typed) begin
			while (wire_expect_q.size() > queued)
				void'(wire_expect_q.pop_back());
			wire_expect_q.push_back(word);
		end
		if (cmd == CMD_END)
			names_sent++;
	endtask

	function automatic logic [7:0] label_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == DOT_CHAR);
		return c;
	endfunction

	task automatic send_random_name();
		logic [7:0] chars [$];
		int kind;
		int labels;
		int len;
		int pick;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) chars.push_back(DOT_CHAR);
			labels = $urandom_range(1, 4);
			for (int l = 0; l < labels; l++) begin
				if (l > 0)
					repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
						chars.push_back(DOT_CHAR);
				pick = $urandom_range(0, 39);
				len = (pick == 0) ? 63 : (pick < 3) ? $urandom_range(55, 62) :
					$urandom_range(1, 10);
				repeat (len) chars.push_back(label_char());
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) chars.push_back(DOT_CHAR);
		end else if (kind < 70) begin
			// overlong label, sometimes with one more label behind it
			repeat ($urandom_range(64, 70)) chars.push_back(label_char());
			if ($urandom_range(0, 1) == 0) begin
				chars.push_back(DOT_CHAR);
				repeat ($urandom_range(1, 5)) chars.push_back(label_char());
			end
		end else if (kind < 73) begin
			// around the name length limit
			len = $urandom_range(250, 258);
			repeat (len - 3)
				chars.push_back(($urandom_range(0, 3) == 0) ? DOT_CHAR : label_char());
			repeat (3) chars.push_back(label_char());
		end else if (kind < 83) begin
			repeat ($urandom_range(0, 4)) chars.push_back(DOT_CHAR);
		end else begin
			repeat ($urandom_range(1, 12))
				chars.push_back(($urandom_range(0, 3) == 0) ? DOT_CHAR :
					8'($urandom_range(0, 255)));
		end
		foreach (chars[i])
			send_word(CMD_CHAR, chars[i], 1'b0, '0);
		send_word(CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic check_wire_word();
		wire_word_t want;
		if (wire_expect_q.size() == 0) begin
			report_mismatch($sformatf("unexpected word %02h last %0b err %0d",
				wire_if.wire_byte, wire_if.last_of_name, wire_if.error_code));
		end else begin
			want = wire_expect_q.pop_front();
			words_checked++;
			if (wire_if.wire_byte !== want.wire_byte)
				report_mismatch($sformatf("wire_byte %02h, expected %02h",
					wire_if.wire_byte, want.wire_byte));
			if (wire_if.last_of_name !== want.last_of_name)
				report_mismatch($sformatf("last_of_name %0b, expected %0b",
					wire_if.last_of_name, want.last_of_name));
			if (wire_if.error_code !== want.error_code)
				report_mismatch($sformatf("error_code %0d, expected %0d",
					wire_if.error_code, want.error_code));
			if (want.last_of_name)
				end_codes[want.error_code]++;
		end
	endtask

	// wire word sink
	initial begin
		wire_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (wire_if.valid && wire_if.ready)
				check_wire_word();
			wire_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((name_if.valid && name_if.ready) || (wire_if.valid && wire_if.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int random_start;
		arst_n            = 1'b0;
		steady            = 1'b0;
		name_if.valid     = 1'b0;
		name_if.cmd       = CMD_CHAR;
		name_if.text_char = 8'h00;
		held_len          = 0;
		full_closed       = 1'b0;
		seen_count        = 0;
		nondot_count      = 0;
		name_err          = ERR_NONE;
		mismatches        = 0;
		items_sent        = 0;
		names_sent        = 0;
		words_checked     = 0;
		end_codes         = '{0, 0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			// long runs go through with no idling on either side
			steady = (directed_rows[r].reps >= MAX_LABEL);
			repeat (directed_rows[r].reps)
				send_word(directed_rows[r].cmd, directed_rows[r].ch,
					directed_rows[r].typed, directed_rows[r].word);
		end
		steady = 1'b0;

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS)
			send_random_name();
		name_if.valid <= 1'b0;

		while (wire_expect_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("sent %0d names in %0d words, checked %0d wire words", names_sent,
			items_sent, words_checked);
		$display("name endings: ok %0d, empty %0d, name too long %0d, label too long %0d",
			end_codes[0], end_codes[1], end_codes[2], end_codes[3]);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/dnwl_pkg.sv
sv/dnwl_in_if.sv
sv/dnwl_out_if.sv
sv/dnwl_ram.sv
sv/dnwl_ctrl.sv
sv/dnwl_dp.sv
sv/domain_name_to_wire_labels.sv
tb/sv/tb.sv
